/* src/yfsp_pkg.sv */
`default_nettype none
package yfsp_pkg;
	localparam int LANES_DEF = 4;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int ACC_W = 40;
	localparam int DIM_W = 13;
	localparam int POS_W = 23;
	localparam int FNUM_W = 24;
	localparam int PSNR_W = 15;
	localparam int LOG_W = 22;
	localparam logic [17:0] TENLOG2_Q16 = 18'd197283;
	localparam logic [16:0] PEAK_SQ = 17'd65025;
	localparam logic [PSNR_W-1:0] PSNR_MAX = 15'd32767;
	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [FNUM_W-1:0] fnum;
		logic              differs;
		logic [ACC_W-1:0]  sse_y;
		logic [ACC_W-1:0]  sse_u;
		logic [ACC_W-1:0]  sse_v;
		logic [26:0]       ylen;
	} frame_res_t;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
	endfunction
endpackage
`default_nettype wire

/* src/yfsp_lane.sv */
`default_nettype none
module yfsp_lane (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [7:0] ref_b,
	input  wire logic [7:0] test_b,
	output logic [15:0]     sq_s1
);
	logic [7:0] ad;
	assign ad = (ref_b >= test_b) ? ref_b - test_b : test_b - ref_b;
	always_ff @(posedge clk) begin
		if (en) sq_s1 <= 16'(ad) * 16'(ad);
	end
endmodule
`default_nettype wire

/* src/yfsp_log2.sv */
`default_nettype none
// Sequential log2 in Q16: one squaring per cycle after a normalize step.
module yfsp_log2 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [56:0] x,
	output logic             done,
	output logic [21:0]      result
);
	localparam logic [1:0] ST_IDLE = 2'd0, ST_NORM = 2'd1, ST_SQ = 2'd2;
	logic [1:0]  state_q;
	logic [56:0] x_q;
	logic [5:0]  msb_q;
	logic [32:0] m_q;
	logic [4:0]  cnt_q;
	logic [15:0] frac_q;
	logic [5:0]  msb;
	logic [65:0] sq;
	logic [34:0] mn;
	always_comb begin
		msb = '0;
		for (int i = 0; i < 57; i++) if (x_q[i]) msb = 6'(i);
	end
	assign sq = 66'(m_q) * 66'(m_q);
	assign mn = sq[65:31];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_NORM;
				ST_NORM: state_q <= ST_SQ;
				ST_SQ: if (cnt_q == 5'd15) begin
					state_q <= ST_IDLE;
					done <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) x_q <= x;
		if (state_q == ST_NORM) begin
			msb_q <= msb;
			m_q <= (msb > 6'd31) ? 33'(x_q >> (msb - 6'd31)) : 33'(x_q << (6'd31 - msb));
			cnt_q <= '0;
			frac_q <= '0;
		end
		if (state_q == ST_SQ) begin
			cnt_q <= cnt_q + 5'd1;
			frac_q <= {frac_q[14:0], mn[32]};
			m_q <= mn[32] ? mn[33:1] : mn[32:0];
		end
	end
	assign result = {msb_q, frac_q};
endmodule
`default_nettype wire

/* src/yfsp_psnr.sv */
`default_nettype none
// Frame-end unit: three log pairs run in turn on one log2 unit.
module yfsp_psnr (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire yfsp_pkg::frame_res_t  res,
	output logic                       busy,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output yfsp_pkg::frame_res_t       res_out,
	output logic [yfsp_pkg::PSNR_W-1:0] p_y,
	output logic [yfsp_pkg::PSNR_W-1:0] p_u,
	output logic [yfsp_pkg::PSNR_W-1:0] p_v
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_LA = 3'd1, ST_WA = 3'd2, ST_LB = 3'd3,
		ST_WB = 3'd4, ST_MUL = 3'd5, ST_OUT = 3'd6;
	localparam int ACC_LOC = yfsp_pkg::ACC_W;
	logic [2:0]  state_q;
	logic [1:0]  plane_q;
	logic [21:0] la_q, lb_q;
	logic        lstart, ldone;
	logic [21:0] lres;
	logic [56:0] lx;
	logic [ACC_LOC-1:0] sse;
	logic [26:0] nlen;
	logic [40:0] prod_s1;
	logic [40:0] rnd;
	logic [yfsp_pkg::PSNR_W-1:0] pq;
	always_comb begin
		unique case (plane_q)
			2'd0: sse = res_out.sse_y;
			2'd1: sse = res_out.sse_u;
			default: sse = res_out.sse_v;
		endcase
	end
	assign nlen = (plane_q == 2'd0) ? res_out.ylen : {2'b00, res_out.ylen[26:2]};
	assign lx = (state_q == ST_LA) ? 57'(nlen) * 57'(yfsp_pkg::PEAK_SQ) : 57'(sse);
	assign lstart = (state_q == ST_LA) || (state_q == ST_LB);
	yfsp_log2 u_log (.clk(clk), .arst_n(arst_n), .start(lstart), .x(lx),
		.done(ldone), .result(lres));
	assign rnd = prod_s1 + 41'd8388608;
	assign pq = (sse == '0 || lb_q >= la_q) ? '0
		: (rnd[40:24] > 17'(yfsp_pkg::PSNR_MAX)) ? yfsp_pkg::PSNR_MAX : rnd[38:24];
	assign busy = state_q != ST_IDLE;
	assign res_valid = state_q == ST_OUT;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_LA;
					plane_q <= '0;
				end
				ST_LA: state_q <= ST_WA;
				ST_WA: if (ldone) state_q <= ST_LB;
				ST_LB: state_q <= ST_WB;
				ST_WB: if (ldone) state_q <= ST_MUL;
				ST_MUL: begin
					if (plane_q == 2'd2) state_q <= ST_OUT;
					else begin
						state_q <= ST_LA;
						plane_q <= plane_q + 2'd1;
					end
				end
				ST_OUT: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) res_out <= res;
		if (state_q == ST_WA && ldone) la_q <= lres;
		if (state_q == ST_WB && ldone) begin
			lb_q <= lres;
			prod_s1 <= 41'(la_q - lres) * 41'(yfsp_pkg::TENLOG2_Q16);
		end
		if (state_q == ST_MUL) begin
			unique case (plane_q)
				2'd0: p_y <= pq;
				2'd1: p_u <= pq;
				default: p_v <= pq;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/yuv420_frame_sse_psnr_core.sv */
`default_nettype none
// Frame SSE/PSNR meter for 8-bit YUV 4:2:0. Each input transfer carries LANES
// reference/test byte pairs; the lanes square the differences into a register and a
// merge stage adds them into the plane's saturating 40-bit sum, so one item is
// taken per cycle during a frame. At the frame's last item the sums are handed to
// the PSNR unit, which runs two log2 evaluations per plane on a shared squaring
// loop; input is held off while that unit is busy.
module yuv420_frame_sse_psnr_core #(
	parameter int MAX_WIDTH = yfsp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = yfsp_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ref_byte_0, ref_byte_1, ref_byte_2, ref_byte_3,
	input  wire logic [7:0]  test_byte_0, test_byte_1, test_byte_2, test_byte_3,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [23:0]      frame_number,
	output logic             frame_differs,
	output logic [39:0]      sse_luma, sse_cb, sse_cr,
	output logic [14:0]      psnr_luma, psnr_cb, psnr_cr
);
	localparam int LANES = yfsp_pkg::LANES_DEF;
	localparam int ACC_W = yfsp_pkg::ACC_W;
	localparam int SQ_W = 16 + $clog2(LANES + 1);
	localparam logic [13:0] LIM_W = 14'(MAX_WIDTH / 4 * 4);
	localparam logic [13:0] LIM_H = 14'(MAX_HEIGHT / 4 * 4);
	logic [12:0] width_q, height_q, w, h;
	logic [22:0] pos_q, pos_s1;
	logic [1:0]  plane_s1;
	logic        last_s1, v_s1;
	logic [ACC_W-1:0] acc_y_q, acc_u_q, acc_v_q;
	logic [23:0] fcnt_q;
	logic [25:0] ylen;
	logic [26:0] ygr, cgr, tot;
	logic [7:0]  rb [4], tb [4];
	logic [15:0] sq_s1 [LANES];
	logic [SQ_W-1:0] sum;
	logic [ACC_W-1:0] ny, nu, nv;
	logic busy, in_fire;
	yfsp_pkg::frame_res_t fr, fr_out;
	function automatic logic [12:0] clampd(input logic [12:0] v, input logic [13:0] lim);
		logic [12:0] t;
		t = {v[12:2], 2'b00};
		if (t < 13'd4) t = 13'd4;
		if (14'(t) > lim) t = lim[12:0];
		clampd = t;
	endfunction
	assign w = clampd(width_q, LIM_W);
	assign h = clampd(height_q, LIM_H);
	assign ylen = 26'(w) * 26'(h);
	assign ygr = 27'(ylen / LANES);
	assign cgr = 27'((ylen >> 2) / LANES);
	assign tot = 27'((27'(ylen) + 27'({ylen[25:2], 1'b0})) / LANES);
	assign rb = '{ref_byte_0, ref_byte_1, ref_byte_2, ref_byte_3};
	assign tb = '{test_byte_0, test_byte_1, test_byte_2, test_byte_3};
	assign cfg_ready = 1'b1;
	assign in_ready = !busy && !(v_s1 && last_s1);
	assign in_fire = in_valid && in_ready;
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		yfsp_lane u_lane (.clk(clk), .en(in_fire), .ref_b(rb[g]), .test_b(tb[g]),
			.sq_s1(sq_s1[g]));
	end
	always_comb begin
		sum = '0;
		for (int i = 0; i < LANES; i++) sum = sum + SQ_W'(sq_s1[i]);
	end
	assign ny = (v_s1 && plane_s1 == 2'd0) ? yfsp_pkg::sat_add(acc_y_q, ACC_W'(sum)) : acc_y_q;
	assign nu = (v_s1 && plane_s1 == 2'd1) ? yfsp_pkg::sat_add(acc_u_q, ACC_W'(sum)) : acc_u_q;
	assign nv = (v_s1 && plane_s1 == 2'd2) ? yfsp_pkg::sat_add(acc_v_q, ACC_W'(sum)) : acc_v_q;
	assign fr = '{fnum: fcnt_q + 24'd1, differs: |{ny, nu, nv}, sse_y: ny, sse_u: nu,
		sse_v: nv, ylen: 27'(ylen)};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd352;
			height_q <= 13'd288;
			pos_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			plane_s1 <= '0;
			acc_y_q <= '0;
			acc_u_q <= '0;
			acc_v_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == yfsp_pkg::REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			v_s1 <= in_fire;
			if (in_fire) begin
				plane_s1 <= (27'(pos_q) < ygr) ? 2'd0 : (27'(pos_q) < ygr + cgr) ? 2'd1 : 2'd2;
				last_s1 <= !(27'(pos_q) + 27'd1 < tot);
				pos_q <= (27'(pos_q) + 27'd1 < tot) ? pos_q + 23'd1 : '0;
			end
			if (v_s1 && last_s1) begin
				acc_y_q <= '0;
				acc_u_q <= '0;
				acc_v_q <= '0;
				fcnt_q <= fcnt_q + 24'd1;
			end else begin
				acc_y_q <= ny;
				acc_u_q <= nu;
				acc_v_q <= nv;
			end
		end
	end
	yfsp_psnr u_psnr (.clk(clk), .arst_n(arst_n), .start(v_s1 && last_s1), .res(fr),
		.busy(busy), .res_valid(out_valid), .res_ready(out_ready), .res_out(fr_out),
		.p_y(psnr_luma), .p_u(psnr_cb), .p_v(psnr_cr));
	assign frame_number = fr_out.fnum;
	assign frame_differs = fr_out.differs;
	assign sse_luma = fr_out.sse_y;
	assign sse_cb = fr_out.sse_u;
	assign sse_cr = fr_out.sse_v;
	assign pos_s1 = pos_q;

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("input taken during frame end");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |=> busy) else $error("frame end not started");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |=> (acc_y_q == '0 && pos_s1 == '0))
		else $error("sums not cleared");
endmodule
`default_nettype wire
